[src/pdot_pkg.sv]
// shared types and constants for the packed delta offset table
package pdot_pkg;

   localparam int OFF_W = 48;
   localparam int IDX_W = 20;
   localparam int CNT_W = 21;
   localparam int SEGB_W = 11;
   localparam int POS_W = 23;
   localparam int ACC_W = 72;
   localparam int NBYTES = 9;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam logic [1:0] STAT_OK = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;
   localparam logic [1:0] STAT_FULL = 2'd3;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [1:0] REG_GROUPED = 2'd0;
   localparam logic [1:0] REG_BASE_BITS = 2'd1;
   localparam logic [1:0] REG_DELTA_BITS = 2'd2;
   localparam logic [1:0] REG_SEGMENTS = 2'd3;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_DIV_G = 11'b000_0000_0010,
      ST_DIV_S = 11'b000_0000_0100,
      ST_POS   = 11'b000_0000_1000,
      ST_FPOS  = 11'b000_0001_0000,
      ST_FETCH = 11'b000_0010_0000,
      ST_FIELD = 11'b000_0100_0000,
      ST_CHECK = 11'b000_1000_0000,
      ST_ALLOC = 11'b001_0000_0000,
      ST_WRITE = 11'b010_0000_0000,
      ST_RESP  = 11'b100_0000_0000
   } state_type;

   typedef enum logic [1:0] {
      FP_GBASE,
      FP_DELTA,
      FP_RMW
   } fetch_type;

endpackage

[src/pdot_div.sv]
// shared restoring divider, one quotient bit per cycle
module pdot_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pdot_pkg::CNT_W-1:0] num,
   input  logic [12:0]                den,
   output logic                       done,
   output logic [pdot_pkg::CNT_W-1:0] quot,
   output logic [12:0]                rem
);
   import pdot_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0] quot_ff, quot_in;
   logic [12:0]      rem_ff, rem_in;
   logic [12:0]      den_ff, den_in;
   logic [13:0]      shifted;
   logic [14:0]      trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      shifted = {rem_ff, quot_ff[CNT_W-1]};
      trial = {1'b0, shifted} - {2'b00, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 5'(CNT_W);
         quot_in = num;
         rem_in = '0;
         den_in = den;
      end else if (busy_ff) begin
         if (trial[14]) begin
            rem_in = shifted[12:0];
         end else begin
            rem_in = trial[12:0];
         end
         quot_in = {quot_ff[CNT_W-2:0], ~trial[14]};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem = rem_ff;

endmodule

[src/packed_delta_offset_table.sv]
// Append-only table of monotone offsets, bit-packed into buckets of BUCKET_BYTES bytes
// (MAX_BUCKETS buckets). tuser 0 appends the offset in tdata, tuser 1 looks up an
// entry; every transaction returns one response with the offset (zero on append or
// error) and a status. One request at a time: locating an entry runs the shared
// serial divider twice, and every packed field is moved as nine bytes through the
// single store port. An append that opens a new bucket first records its base in the
// bucket base store; errors found before the division answer on the next cycle. No
// clearing pass after reset.
module packed_delta_offset_table #(
   parameter int BUCKET_BYTES = 4096,
   parameter int MAX_BUCKETS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // offset_value[47:0], entry_index[67:48]
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // offset_out[47:0], status[49:48]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pdot_pkg::*;

   localparam int DEPTH = BUCKET_BYTES * MAX_BUCKETS;
   localparam int AW = $clog2(DEPTH);
   localparam int BKT_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int UW = $clog2(MAX_BUCKETS + 1);
   localparam logic [POS_W:0] BUCKET_BITS = (POS_W+1)'(BUCKET_BYTES * 8);

   logic [7:0]     store_mem [DEPTH];
   logic [OFF_W-1:0] bases_mem [MAX_BUCKETS];

   logic [4:0]  grp_ff, grp_in;
   logic [5:0]  bbits_ff, bbits_in;
   logic [5:0]  dbits_ff, dbits_in;
   logic [12:0] spb_ff, spb_in;
   logic [4:0]  g_eff;
   logic [12:0] spb_eff;

   state_type        state_ff, state_in;
   fetch_type        ph_ff, ph_in;
   logic             cmd_ff, cmd_in;
   logic [OFF_W-1:0] off_ff, off_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [OFF_W-1:0] last_ff, last_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [4:0]       rel_ff, rel_in;
   logic [SEGB_W-1:0] segb_ff, segb_in;
   logic [SEGB_W-1:0] dofs_ff, dofs_in;
   logic [CNT_W-1:0] bkt_ff, bkt_in;
   logic [12:0]      srem_ff, srem_in;
   logic [POS_W-1:0] gpos_ff, gpos_in;
   logic [POS_W-1:0] fpos_ff, fpos_in;
   logic [POS_W-1:0] fp_ff, fp_in;
   logic [5:0]       fw_ff, fw_in;
   logic [3:0]       k_ff, k_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [NBYTES-1:0] bv_ff, bv_in;
   logic             vld_d_ff;
   logic [63:0]      sum_ff, sum_in;
   logic [62:0]      val_ff, val_in;
   logic [OFF_W-1:0] out_ff, out_in;
   logic [1:0]       stat_ff, stat_in;
   logic [7:0]       st_rd_ff;
   logic [OFF_W-1:0] bases_rd_ff;

   logic             div_start, div_done;
   logic [CNT_W-1:0] div_num, div_quot;
   logic [12:0]      div_den, div_rem;

   logic             req_ok, cfg_wr;
   logic [20:0]      bidx;
   logic             bvalid;
   logic [AW-1:0]    st_addr;
   logic             st_we;
   logic [BKT_W-1:0] bkt_lo;
   logic             bases_we;
   logic [3:0]       kk;
   logic [ACC_W-1:0] byte_mask, acc_m, fmask, merged;
   logic [63:0]      field;
   logic [5:0]       w_sel;
   logic [POS_W:0]   end_pos;
   logic [63:0]      diff;
   logic [CNT_W-1:0] lookup_idx;

   pdot_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign g_eff = (grp_ff == 5'd0) ? 5'd1 : grp_ff;
   assign spb_eff = (spb_ff == 13'd0) ? 13'd1 : spb_ff;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_ok = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign rsp_tdata = {6'b0, stat_ff, out_ff};
   assign lookup_idx = {1'b0, req_tdata[67:48]};

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      grp_in = grp_ff;
      bbits_in = bbits_ff;
      dbits_in = dbits_ff;
      spb_in = spb_ff;
      csr_prdata = '0;
      case (csr_paddr[3:2])
         REG_GROUPED:    csr_prdata = {27'b0, grp_ff};
         REG_BASE_BITS:  csr_prdata = {26'b0, bbits_ff};
         REG_DELTA_BITS: csr_prdata = {26'b0, dbits_ff};
         REG_SEGMENTS:   csr_prdata = {19'b0, spb_ff};
         default:        csr_prdata = '0;
      endcase
      if (cfg_wr) begin
         case (csr_paddr[3:2])
            REG_GROUPED:    grp_in = csr_pwdata[4:0];
            REG_BASE_BITS:  bbits_in = csr_pwdata[5:0];
            REG_DELTA_BITS: dbits_in = csr_pwdata[5:0];
            REG_SEGMENTS:   spb_in = csr_pwdata[12:0];
            default:        grp_in = grp_ff;
         endcase
      end
   end

   // byte addressing for field transfers
   assign bidx = 21'(fp_ff[POS_W-1:3]) + 21'(k_ff);
   assign bvalid = (bidx < 21'(BUCKET_BYTES));
   assign bkt_lo = bkt_ff[BKT_W-1:0];
   assign st_addr = bvalid ? AW'(32'(bkt_lo) * 32'(BUCKET_BYTES) + 32'(bidx)) : '0;
   assign kk = k_ff - 4'd1;

   always_comb begin
      for (int i = 0; i < NBYTES; i++) begin
         byte_mask[8*i +: 8] = {8{bv_ff[i]}};
      end
   end

   assign acc_m = acc_ff & byte_mask;
   assign field = 64'(acc_m >> fp_ff[2:0]) & ((64'(1) << fw_ff) - 64'd1);
   assign fmask = ACC_W'((64'(1) << fw_ff) - 64'd1) << fp_ff[2:0];
   assign merged = (acc_ff & ~fmask) | ((ACC_W'(val_ff) << fp_ff[2:0]) & fmask);

   assign w_sel = (rel_ff == 5'd0) ? bbits_ff : dbits_ff;
   assign end_pos = {1'b0, fpos_ff} + (POS_W+1)'(w_sel);
   assign diff = {16'b0, off_ff} - sum_ff;

   always_comb begin
      state_in = state_ff;
      ph_in = ph_ff;
      cmd_in = cmd_ff;
      off_in = off_ff;
      count_in = count_ff;
      last_in = last_ff;
      used_in = used_ff;
      rel_in = rel_ff;
      segb_in = segb_ff;
      dofs_in = dofs_ff;
      bkt_in = bkt_ff;
      srem_in = srem_ff;
      gpos_in = gpos_ff;
      fpos_in = fpos_ff;
      fp_in = fp_ff;
      fw_in = fw_ff;
      k_in = k_ff;
      acc_in = acc_ff;
      bv_in = bv_ff;
      sum_in = sum_ff;
      val_in = val_ff;
      out_in = out_ff;
      stat_in = stat_ff;
      div_start = 1'b0;
      div_num = '0;
      div_den = '0;
      st_we = 1'b0;
      bases_we = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ok) begin
               cmd_in = req_tuser;
               off_in = req_tdata[47:0];
               out_in = '0;
               segb_in = SEGB_W'(bbits_ff) +
                         SEGB_W'(g_eff - 5'd1) * SEGB_W'(dbits_ff);
               if (req_tuser == CMD_LOOKUP) begin
                  if (lookup_idx >= count_ff) begin
                     stat_in = STAT_RANGE;
                     state_in = ST_RESP;
                  end else begin
                     div_start = 1'b1;
                     div_num = lookup_idx;
                     div_den = {8'b0, g_eff};
                     state_in = ST_DIV_G;
                  end
               end else begin
                  if (count_ff == COUNT_MAX) begin
                     stat_in = STAT_FULL;
                     state_in = ST_RESP;
                  end else begin
                     div_start = 1'b1;
                     div_num = count_ff;
                     div_den = {8'b0, g_eff};
                     state_in = ST_DIV_G;
                  end
               end
            end
         end
         ST_DIV_G: begin
            if (div_done) begin
               rel_in = div_rem[4:0];
               div_start = 1'b1;
               div_num = div_quot;
               div_den = spb_eff;
               state_in = ST_DIV_S;
            end
         end
         ST_DIV_S: begin
            if (div_done) begin
               bkt_in = div_quot;
               srem_in = div_rem;
               if (div_quot >= CNT_W'(MAX_BUCKETS)) begin
                  stat_in = (cmd_ff == CMD_LOOKUP) ? STAT_RANGE : STAT_FULL;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_POS;
               end
            end
         end
         ST_POS: begin
            gpos_in = POS_W'(srem_ff * segb_ff);
            dofs_in = SEGB_W'(bbits_ff) + SEGB_W'(rel_ff - 5'd1) * SEGB_W'(dbits_ff);
            state_in = ST_FPOS;
         end
         ST_FPOS: begin
            fpos_in = gpos_ff + ((rel_ff == 5'd0) ? '0 : POS_W'(dofs_ff));
            if (cmd_ff == CMD_LOOKUP || bkt_ff < CNT_W'(used_ff)) begin
               sum_in = 64'(bases_rd_ff);
            end else begin
               sum_in = 64'(last_ff);
            end
            if (cmd_ff == CMD_LOOKUP || rel_ff != 5'd0) begin
               fp_in = gpos_ff;
               fw_in = bbits_ff;
               ph_in = FP_GBASE;
               k_in = '0;
               state_in = ST_FETCH;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_FETCH: begin
            if (k_ff != 4'd0) begin
               acc_in[{kk[3:0], 3'b000} +: 8] = st_rd_ff;
               bv_in[kk] = vld_d_ff;
            end
            if (k_ff == 4'(NBYTES)) begin
               state_in = ST_FIELD;
            end else begin
               k_in = k_ff + 4'd1;
            end
         end
         ST_FIELD: begin
            case (ph_ff)
               FP_GBASE: begin
                  sum_in = sum_ff + field;
                  if (cmd_ff == CMD_LOOKUP) begin
                     if (rel_ff != 5'd0) begin
                        fp_in = fpos_ff;
                        fw_in = dbits_ff;
                        ph_in = FP_DELTA;
                        k_in = '0;
                        state_in = ST_FETCH;
                     end else begin
                        out_in = sum_in[OFF_W-1:0];
                        stat_in = STAT_OK;
                        state_in = ST_RESP;
                     end
                  end else begin
                     state_in = ST_CHECK;
                  end
               end
               FP_DELTA: begin
                  sum_in = sum_ff + field;
                  out_in = sum_in[OFF_W-1:0];
                  stat_in = STAT_OK;
                  state_in = ST_RESP;
               end
               FP_RMW: begin
                  k_in = '0;
                  state_in = ST_WRITE;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_CHECK: begin
            if (end_pos > BUCKET_BITS) begin
               stat_in = STAT_FULL;
               state_in = ST_RESP;
            end else if ((diff >> w_sel) != 64'd0) begin
               stat_in = STAT_OVERFLOW;
               state_in = ST_RESP;
            end else begin
               val_in = diff[62:0];
               fp_in = fpos_ff;
               fw_in = w_sel;
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            if (CNT_W'(used_ff) <= bkt_ff) begin
               bases_we = 1'b1;
               used_in = used_ff + UW'(1);
            end else begin
               ph_in = FP_RMW;
               k_in = '0;
               state_in = ST_FETCH;
            end
         end
         ST_WRITE: begin
            st_we = bv_ff[k_ff];
            if (k_ff == 4'(NBYTES - 1)) begin
               last_in = off_ff;
               count_in = count_ff + CNT_W'(1);
               stat_in = STAT_OK;
               state_in = ST_RESP;
            end else begin
               k_in = k_ff + 4'd1;
            end
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff <= 5'd1;
         bbits_ff <= 6'd32;
         dbits_ff <= 6'd16;
         spb_ff <= 13'd1000;
         state_ff <= ST_IDLE;
         count_ff <= '0;
         last_ff <= '0;
         used_ff <= '0;
      end else begin
         grp_ff <= grp_in;
         bbits_ff <= bbits_in;
         dbits_ff <= dbits_in;
         spb_ff <= spb_in;
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff <= last_in;
         used_ff <= used_in;
      end
      ph_ff <= ph_in;
      cmd_ff <= cmd_in;
      off_ff <= off_in;
      rel_ff <= rel_in;
      segb_ff <= segb_in;
      dofs_ff <= dofs_in;
      bkt_ff <= bkt_in;
      srem_ff <= srem_in;
      gpos_ff <= gpos_in;
      fpos_ff <= fpos_in;
      fp_ff <= fp_in;
      fw_ff <= fw_in;
      k_ff <= k_in;
      acc_ff <= acc_in;
      bv_ff <= bv_in;
      vld_d_ff <= bvalid;
      sum_ff <= sum_in;
      val_ff <= val_in;
      out_ff <= out_in;
      stat_ff <= stat_in;
   end

   // packed byte store
   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_addr] <= merged[{k_ff, 3'b000} +: 8];
      end
      st_rd_ff <= store_mem[st_addr];
   end

   // bucket base store
   always_ff @(posedge clock) begin
      if (bases_we) begin
         bases_mem[used_ff[BKT_W-1:0]] <= last_ff;
      end
      bases_rd_ff <= bases_mem[bkt_lo];
   end

endmodule

[src/pdot_check.sv]
// port-level checker for the packed delta offset table and its bind
module pdot_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   import pdot_pkg::*;

   // one transaction in flight at a time
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request side ready while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready again right after an accepted request");

   // errors carry no offset
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[49:48] != STAT_OK |-> rsp_tdata[47:0] == 48'd0)
      else $error("error response with a nonzero offset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_append_no_range: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == CMD_APPEND |=>
      !(rsp_tvalid && rsp_tdata[49:48] == STAT_RANGE))
      else $error("append answered with a range error");

endmodule

bind packed_delta_offset_table pdot_check u_pdot_check (.*);
